/* design/spoe_pkg.sv */
// Shared types and constants for the slot pool with oldest-slot eviction.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package spoe_pkg;

   localparam int POOL_SLOTS_DEFAULT = 1024;
   localparam int SLOTS_RESET        = 1024;
   localparam int CFG_W              = 11;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UNLINK,
      ST_LINK
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_POP,
      OP_EVICT,
      OP_FREE
   } op_type;

   typedef struct packed {
      logic accept;
      logic unlink;
      logic link;
   } ctl_cmd_type;

endpackage

/* design/spoe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module spoe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/spoe_ctrl.sv */
// Request sequencer: accept, unlink step, link step with result load.
// Depends on spoe_pkg.
`timescale 1ns / 1ps

module spoe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 out_free,
   output spoe_pkg::ctl_cmd_type cmd
);

   import spoe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UNLINK;
            end
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = ST_LINK;
         end
         ST_LINK: begin
            // hold until the result register can take the beat
            if (out_free) begin
               cmd.link = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/spoe_datapath.sv */
// Pool state, link memories, free-stack and list pointers, result register.
// Depends on spoe_pkg and spoe_ram.
`timescale 1ns / 1ps

module spoe_datapath #(
   parameter int POOL_SLOTS = spoe_pkg::POOL_SLOTS_DEFAULT,
   localparam int SW        = $clog2(POOL_SLOTS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spoe_pkg::ctl_cmd_type       cmd,
   output logic                        out_free,
   input  logic                        csr_wen,
   input  logic [spoe_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                        req_type,
   input  logic [SW-1:0]               req_slot,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [SW-1:0]               rsp_granted,
   output logic                        rsp_evicted,
   output logic [SW-1:0]               rsp_evslot,
   output logic                        rsp_status
);

   import spoe_pkg::*;

   localparam int LW = $clog2(POOL_SLOTS + 1);
   localparam int PW = LW + 1;
   localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);
   localparam logic [LW-1:0] N_RESET =
      LW'((SLOTS_RESET > POOL_SLOTS) ? POOL_SLOTS : SLOTS_RESET);

   // pool pointers
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] fresh_ff, fresh_in;
   logic [LW-1:0] top_ff, top_in;
   logic [LW-1:0] newest_ff, newest_in;
   logic [LW-1:0] oldest_ff, oldest_in;
   // request in flight
   op_type        op_ff, op_in;
   logic [LW-1:0] slot_ff, slot_in;
   logic          ok_ff, ok_in;
   // result register
   logic          rvalid_ff, rvalid_in;
   logic [SW-1:0] granted_ff, granted_in;
   logic          evicted_ff, evicted_in;
   logic [SW-1:0] evslot_ff, evslot_in;
   logic          status_ff, status_in;

   // link memory ports
   logic          nxt_we, prv_we, rd_en;
   logic [SW-1:0] nxt_wa, prv_wa, rd_addr;
   logic [LW-1:0] nxt_wd, nxt_rd;
   logic [PW-1:0] prv_wd, prv_rd;

   op_type        acc_op;
   logic [LW-1:0] acc_slot;
   logic [LW-1:0] newer, older, succ;
   logic          act, fresh_pop;
   logic [31:0]   cfg_wide;
   logic [LW-1:0] cfg_count;

   // prev memory word holds the active flag above the newer-neighbor link
   spoe_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_next_ram (
      .clock (clock),
      .we    (nxt_we),
      .waddr (nxt_wa),
      .wdata (nxt_wd),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (nxt_rd)
   );

   spoe_ram #(.WIDTH(PW), .DEPTH(POOL_SLOTS)) u_prev_ram (
      .clock (clock),
      .we    (prv_we),
      .waddr (prv_wa),
      .wdata (prv_wd),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (prv_rd)
   );

   always_comb begin
      if (req_type == REQ_FREE) begin
         acc_op   = OP_FREE;
         acc_slot = LW'(req_slot);
      end else if (top_ff < NIL) begin
         acc_op   = OP_POP;
         acc_slot = top_ff;
      end else if (oldest_ff < NIL) begin
         acc_op   = OP_EVICT;
         acc_slot = oldest_ff;
      end else begin
         acc_op   = OP_NONE;
         acc_slot = '0;
      end
   end

   always_comb begin
      cfg_wide = 32'(csr_wdata);
      if (cfg_wide == 32'd0) begin
         cfg_count = LW'(1);
      end else if (cfg_wide > 32'(POOL_SLOTS)) begin
         cfg_count = NIL;
      end else begin
         cfg_count = LW'(cfg_wide);
      end
   end

   assign newer     = prv_rd[LW-1:0];
   assign older     = nxt_rd;
   assign act       = prv_rd[LW];
   assign succ      = slot_ff + LW'(1);
   assign fresh_pop = (slot_ff >= fresh_ff);
   assign rd_en     = cmd.accept;
   assign rd_addr   = acc_slot[SW-1:0];
   assign out_free  = !rvalid_ff || rsp_tready;

   always_comb begin
      n_in       = n_ff;
      fresh_in   = fresh_ff;
      top_in     = top_ff;
      newest_in  = newest_ff;
      oldest_in  = oldest_ff;
      op_in      = op_ff;
      slot_in    = slot_ff;
      ok_in      = ok_ff;
      rvalid_in  = rvalid_ff && !rsp_tready;
      granted_in = granted_ff;
      evicted_in = evicted_ff;
      evslot_in  = evslot_ff;
      status_in  = status_ff;
      nxt_we     = 1'b0;
      nxt_wa     = '0;
      nxt_wd     = '0;
      prv_we     = 1'b0;
      prv_wa     = '0;
      prv_wd     = '0;

      if (cmd.accept) begin
         op_in   = acc_op;
         slot_in = acc_slot;
      end

      if (cmd.unlink) begin
         case (op_ff)
            OP_FREE: begin
               // slots at or above the fresh mark were never handed out
               ok_in = (slot_ff < fresh_ff) && act;
               if ((slot_ff < fresh_ff) && act) begin
                  if (newer < NIL) begin
                     nxt_we = 1'b1;
                     nxt_wa = newer[SW-1:0];
                     nxt_wd = older;
                  end else begin
                     newest_in = older;
                  end
                  if (older < NIL) begin
                     prv_we = 1'b1;
                     prv_wa = older[SW-1:0];
                     prv_wd = {1'b1, newer};
                  end else begin
                     oldest_in = newer;
                  end
               end
            end
            OP_EVICT: begin
               // drop the tail; it is relinked at the head in the link step
               ok_in = 1'b1;
               if (newer < NIL) begin
                  nxt_we    = 1'b1;
                  nxt_wa    = newer[SW-1:0];
                  nxt_wd    = NIL;
                  oldest_in = newer;
               end else begin
                  newest_in = NIL;
                  oldest_in = NIL;
               end
               prv_we = 1'b1;
               prv_wa = slot_ff[SW-1:0];
               prv_wd = {1'b1, NIL};
            end
            OP_POP: begin
               ok_in = 1'b1;
               if (fresh_pop) begin
                  fresh_in = succ;
                  top_in   = (succ < n_ff) ? succ : NIL;
               end else begin
                  top_in = nxt_rd;
               end
               nxt_we = 1'b1;
               nxt_wa = slot_ff[SW-1:0];
               nxt_wd = newest_ff;
               prv_we = 1'b1;
               prv_wa = slot_ff[SW-1:0];
               prv_wd = {1'b1, NIL};
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end

      if (cmd.link) begin
         rvalid_in  = 1'b1;
         granted_in = '0;
         evicted_in = 1'b0;
         evslot_in  = '0;
         status_in  = 1'b0;
         case (op_ff)
            OP_FREE: begin
               status_in = !ok_ff;
               if (ok_ff) begin
                  nxt_we = 1'b1;
                  nxt_wa = slot_ff[SW-1:0];
                  nxt_wd = top_ff;
                  prv_we = 1'b1;
                  prv_wa = slot_ff[SW-1:0];
                  prv_wd = {1'b0, NIL};
                  top_in = slot_ff;
               end
            end
            OP_EVICT, OP_POP: begin
               if (op_ff == OP_EVICT) begin
                  nxt_we     = 1'b1;
                  nxt_wa     = slot_ff[SW-1:0];
                  nxt_wd     = newest_ff;
                  evicted_in = 1'b1;
                  evslot_in  = slot_ff[SW-1:0];
               end
               if (newest_ff < NIL) begin
                  prv_we = 1'b1;
                  prv_wa = newest_ff[SW-1:0];
                  prv_wd = {1'b1, slot_ff};
               end else begin
                  oldest_in = slot_ff;
               end
               newest_in  = slot_ff;
               granted_in = slot_ff[SW-1:0];
            end
            default: begin
               status_in = 1'b0;
            end
         endcase
      end

      if (csr_wen) begin
         n_in      = cfg_count;
         fresh_in  = '0;
         top_in    = '0;
         newest_in = NIL;
         oldest_in = NIL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= N_RESET;
         fresh_ff  <= '0;
         top_ff    <= '0;
         newest_ff <= NIL;
         oldest_ff <= NIL;
         op_ff     <= OP_NONE;
         rvalid_ff <= 1'b0;
      end else begin
         n_ff      <= n_in;
         fresh_ff  <= fresh_in;
         top_ff    <= top_in;
         newest_ff <= newest_in;
         oldest_ff <= oldest_in;
         op_ff     <= op_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      ok_ff      <= ok_in;
      granted_ff <= granted_in;
      evicted_ff <= evicted_in;
      evslot_ff  <= evslot_in;
      status_ff  <= status_in;
   end

   assign rsp_tvalid  = rvalid_ff;
   assign rsp_granted = granted_ff;
   assign rsp_evicted = evicted_ff;
   assign rsp_evslot  = evslot_ff;
   assign rsp_status  = status_ff;

`ifndef SYNTHESIS
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= n_ff)
      else $error("fresh mark passed the slot count");

   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      (newest_ff == NIL) == (oldest_ff == NIL))
      else $error("active list head and tail disagree on emptiness");

   a_link_room: assert property (@(posedge clock) disable iff (reset)
      cmd.link |-> (!rvalid_ff || rsp_tready))
      else $error("result loaded over a beat not yet taken");

   a_grant_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.link && (op_ff == OP_POP || op_ff == OP_EVICT) && !csr_wen)
      |=> (newest_ff == $past(slot_ff)))
      else $error("granted slot did not become the list head");
`endif

endmodule

/* design/slot_pool_oldest_eviction_unit.sv */
// Top level of the slot pool allocator with oldest-slot eviction.
// Depends on spoe_pkg, spoe_ctrl, spoe_datapath (and spoe_ram below it).
// Each request passes the read, unlink and link steps on the single-write-port
// link memories, and its result beat is loaded in the link step; a new request
// is taken only after that link step. An untaken result beat holds the link step.
// Reset (synchronous) and any csr write re-initialize the pool at once with
//   no clearing pass: a fresh-slot mark stands in for the initial free chain.
`timescale 1ns / 1ps

module slot_pool_oldest_eviction_unit #(
   parameter int POOL_SLOTS = spoe_pkg::POOL_SLOTS_DEFAULT,
   localparam int SW        = $clog2(POOL_SLOTS),
   localparam int REQ_DW    = ((SW + 7) / 8) * 8,
   localparam int RSP_DW    = ((2 * SW + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DW-1:0]          req_tdata,  // slot_index, zero pad
   input  logic                       req_tuser,  // req_type
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DW-1:0]          rsp_tdata,  // granted_slot, evicted_slot, zero pad
   output logic [1:0]                 rsp_tuser,  // evicted, status
   // slot count register
   input  logic                       csr_wen,
   input  logic [spoe_pkg::CFG_W-1:0] csr_wdata
);

   import spoe_pkg::*;

   ctl_cmd_type   cmd;
   logic          out_free;
   logic [SW-1:0] granted;
   logic [SW-1:0] evslot;
   logic          evicted;
   logic          status;

   // sequence each request: accept and read, unlink, link and load result
   spoe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   // link memories, stack and list pointers, and the result register
   spoe_datapath #(.POOL_SLOTS(POOL_SLOTS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .out_free    (out_free),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .req_type    (req_tuser),
      .req_slot    (req_tdata[SW-1:0]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_granted (granted),
      .rsp_evicted (evicted),
      .rsp_evslot  (evslot),
      .rsp_status  (status)
   );

   // pack the result beat, lowest field first
   assign rsp_tdata = RSP_DW'({evslot, granted});
   assign rsp_tuser = {status, evicted};

endmodule
